// File: sv/uart_ring_buffer_pair_defines.svh
// Assertion macros for the UART ring buffer pair.
`ifndef UART_RING_BUFFER_PAIR_DEFINES_SVH
`define UART_RING_BUFFER_PAIR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define URBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urbp assertion failed");

// Next-cycle implication, disabled during reset.
`define URBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urbp assertion failed");

`endif

// File: sv/urbp_pkg.sv
// Package for the UART ring buffer pair: sizes, function codes and transfer types.
package urbp_pkg;

  localparam int TX_DEPTH = 256;
  localparam int RX_DEPTH = 256;

  localparam int TX_PTR_W  = $clog2(TX_DEPTH);
  localparam int RX_PTR_W  = $clog2(RX_DEPTH);
  localparam int TX_CNT_W  = TX_PTR_W + 1;
  localparam int MSG_LEN_W = 10;
  localparam int TX_CMP_W  = (TX_CNT_W > MSG_LEN_W) ? TX_CNT_W : MSG_LEN_W;

  localparam logic [1:0] FUNC_LINE_RX  = 2'd0;
  localparam logic [1:0] FUNC_APP_READ = 2'd1;
  localparam logic [1:0] FUNC_APP_SEND = 2'd2;
  localparam logic [1:0] FUNC_TX_READY = 2'd3;

  typedef struct packed {
    logic [1:0]           func;
    logic [7:0]           data_in;
    logic                 rx_error;
    logic [MSG_LEN_W-1:0] msg_len;
    logic                 msg_first;
  } in_item_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       send_accepted;
    logic       rx_dropped;
    logic       tx_active;
    logic       sending;
  } out_item_t;

endpackage

// File: sv/uart_ring_buffer_pair.sv
// UART receive and transmit ring buffers with application and line side operations.
//
// One item per cycle sustained while out_stall is low: ring pointers, the
// transmit enable and the message flag are updated when an item is accepted,
// and the single read port of each byte store registers its data together
// with the holding stage ahead of the output register. Each ring holds at
// most depth minus one bytes. Stores are not cleared after reset.

`include "uart_ring_buffer_pair_defines.svh"

module uart_ring_buffer_pair
  import urbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);
  localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
  localparam logic [TX_CNT_W-1:0] TX_CAP  = TX_CNT_W'(TX_DEPTH - 1);
  localparam logic [TX_CNT_W-1:0] TX_SPAN = TX_CNT_W'(TX_DEPTH);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_rdata_r;
  logic [7:0] rx_rdata_r;

  logic [TX_PTR_W-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt, tx_wp_inc, tx_rp_inc;
  logic [RX_PTR_W-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt, rx_wp_inc, rx_rp_inc;
  logic                tx_en_r, tx_en_nxt;
  logic                msg_ok_r, msg_ok_nxt;

  logic                s1_valid_r, s1_valid_nxt;
  out_item_t           s1_item_r, s1_item_nxt;
  logic                s1_rx_rd_r, s1_tx_rd_r;
  out_item_t           s1_merged;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r;

  logic                in_acc, s1_adv;
  logic                tx_we, tx_re, rx_we, rx_re;
  logic [TX_CNT_W-1:0] tx_used, tx_free;
  logic [TX_CMP_W-1:0] tx_free_ext, len_ext;
  logic                send_ok;

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign tx_wp_inc = (tx_wp_r == TX_LAST) ? '0 : tx_wp_r + 1'b1;
  assign tx_rp_inc = (tx_rp_r == TX_LAST) ? '0 : tx_rp_r + 1'b1;
  assign rx_wp_inc = (rx_wp_r == RX_LAST) ? '0 : rx_wp_r + 1'b1;
  assign rx_rp_inc = (rx_rp_r == RX_LAST) ? '0 : rx_rp_r + 1'b1;

  assign tx_used = (tx_wp_r >= tx_rp_r)
                 ? {1'b0, tx_wp_r} - {1'b0, tx_rp_r}
                 : {1'b0, tx_wp_r} + TX_SPAN - {1'b0, tx_rp_r};
  assign tx_free     = TX_CAP - tx_used;
  assign tx_free_ext = TX_CMP_W'(tx_free);
  assign len_ext     = TX_CMP_W'(in_item.msg_len);

  always_comb begin
    tx_wp_nxt   = tx_wp_r;
    tx_rp_nxt   = tx_rp_r;
    rx_wp_nxt   = rx_wp_r;
    rx_rp_nxt   = rx_rp_r;
    tx_en_nxt   = tx_en_r;
    msg_ok_nxt  = msg_ok_r;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    send_ok     = 1'b0;
    s1_item_nxt = '0;
    if (in_acc) begin
      unique case (in_item.func)
        FUNC_LINE_RX: begin
          if (in_item.rx_error || rx_wp_inc == rx_rp_r) begin
            s1_item_nxt.rx_dropped = 1'b1;
          end else begin
            rx_we     = 1'b1;
            rx_wp_nxt = rx_wp_inc;
          end
        end
        FUNC_APP_READ: begin
          if (rx_rp_r != rx_wp_r) begin
            rx_re                  = 1'b1;
            rx_rp_nxt              = rx_rp_inc;
            s1_item_nxt.read_valid = 1'b1;
          end
        end
        FUNC_APP_SEND: begin
          send_ok = in_item.msg_first
                  ? ((in_item.msg_len != '0) && (len_ext <= tx_free_ext))
                  : msg_ok_r;
          msg_ok_nxt = send_ok;
          if (send_ok && tx_wp_inc != tx_rp_r) begin
            tx_we                     = 1'b1;
            tx_wp_nxt                 = tx_wp_inc;
            tx_en_nxt                 = 1'b1;
            s1_item_nxt.send_accepted = 1'b1;
          end
        end
        FUNC_TX_READY: begin
          if (tx_rp_r != tx_wp_r) begin
            tx_re                  = 1'b1;
            tx_rp_nxt              = tx_rp_inc;
            s1_item_nxt.line_valid = 1'b1;
          end else begin
            tx_en_nxt = 1'b0;
          end
        end
      endcase
    end
    s1_item_nxt.tx_active = tx_en_nxt;
    s1_item_nxt.sending   = (tx_rp_nxt != tx_wp_nxt) || tx_en_nxt;
  end

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  // Byte stores: write at the slot being filled, read data registered.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wp_r] <= in_item.data_in;
    end
    if (tx_re) begin
      tx_rdata_r <= tx_mem[tx_rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wp_r] <= in_item.data_in;
    end
    if (rx_re) begin
      rx_rdata_r <= rx_mem[rx_rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wp_r     <= '0;
      tx_rp_r     <= '0;
      rx_wp_r     <= '0;
      rx_rp_r     <= '0;
      tx_en_r     <= 1'b0;
      msg_ok_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tx_wp_r     <= tx_wp_nxt;
      tx_rp_r     <= tx_rp_nxt;
      rx_wp_r     <= rx_wp_nxt;
      rx_rp_r     <= rx_rp_nxt;
      tx_en_r     <= tx_en_nxt;
      msg_ok_r    <= msg_ok_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r  <= s1_item_nxt;
      s1_rx_rd_r <= rx_re;
      s1_tx_rd_r <= tx_re;
    end
  end

  // Merge store read data into the result on its way to the output register.
  always_comb begin
    s1_merged           = s1_item_r;
    s1_merged.read_byte = s1_rx_rd_r ? rx_rdata_r : 8'd0;
    s1_merged.line_byte = s1_tx_rd_r ? tx_rdata_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= s1_merged;
    end
  end

  `URBP_ASSERT_NOW(a_stall_only_when_held, in_stall, s1_valid_r && out_valid_r && out_stall)
  `URBP_ASSERT_NEXT(a_rx_write_fills, rx_we, rx_wp_r != rx_rp_r)
  `URBP_ASSERT_NEXT(a_send_enables_tx, in_acc && s1_item_nxt.send_accepted, tx_en_r)
  `URBP_ASSERT_NOW(a_read_flags_match, s1_valid_r, s1_rx_rd_r == s1_item_r.read_valid)

endmodule
